@@ sv/bib_pkg.sv @@
`timescale 1ns / 1ps
package bib_pkg;

  localparam int unsigned MaxHeight    = 4096;
  localparam int unsigned MaxLineBytes = 512;

  // Configuration register indexes.
  localparam logic [1:0] CfgOneBitMode = 2'd0;
  localparam logic [1:0] CfgWidth      = 2'd1;
  localparam logic [1:0] CfgHeight     = 2'd2;
  localparam logic [1:0] CfgLineBytes  = 2'd3;

  typedef struct packed {
    logic        one_bit_mode;
    logic [12:0] width;
    logic [12:0] height;
    logic [9:0]  line_bytes;
  } cfg_t;

  typedef struct packed {
    logic [11:0] row_count;
    logic [8:0]  byte_col;
    logic [12:0] min_drow;
    logic [11:0] max_drow;
    logic [12:0] min_col;
    logic [11:0] max_col;
    logic        any_set;
  } frame_t;

  typedef struct packed {
    logic [12:0] top_row;
    logic [11:0] bottom_row;
    logic [12:0] left_col;
    logic [11:0] right_col;
    logic        empty_frame;
  } result_t;

  localparam frame_t FrameClear = '{
    row_count: '0,
    byte_col:  '0,
    min_drow:  '1,
    max_drow:  '0,
    min_col:   '1,
    max_col:   '0,
    any_set:   1'b0
  };

  // Offset from the MSB of the leftmost set pixel.
  function automatic logic [2:0] first_set(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (b[7-k]) begin
        idx = 3'(k);
      end
    end
    return idx;
  endfunction

  // Offset from the MSB of the rightmost set pixel.
  function automatic logic [2:0] last_set(input logic [7:0] b);
    logic [2:0] idx;
    idx = 3'd7;
    for (int k = 0; k < 8; k++) begin
      if (b[7-k]) begin
        idx = 3'(k);
      end
    end
    return idx;
  endfunction

endpackage

@@ sv/binary_image_bounding_box.sv @@
`timescale 1ns / 1ps
// Takes one pixel byte per cycle. An accepted byte lands in the input register and is folded
// into the running box from there; the result of a frame is loaded into the result register
// as its last byte is folded. Throughput is one byte per cycle; only a frame-end byte waits,
// and only while the result register still holds an untaken result.
// Reset restores the register defaults, clears the frame counters and empties both stages.
module binary_image_bounding_box (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  pixel_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [12:0] top_row_o,
  output logic [11:0] bottom_row_o,
  output logic [12:0] left_col_o,
  output logic [11:0] right_col_o,
  output logic        empty_frame_o,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i
);

  bib_pkg::cfg_t    cfg_q;
  bib_pkg::frame_t  frame_q;
  bib_pkg::frame_t  frame_d;
  bib_pkg::result_t result_d;
  bib_pkg::result_t out_q;
  logic             s1_valid_q;
  logic [7:0]       s1_byte_q;
  logic             out_valid_q;
  logic             frame_end;
  logic             out_free;
  logic             s1_fire;
  logic             in_accept;

  bib_step u_step (
    .cfg_i        (cfg_q),
    .frame_i      (frame_q),
    .pixel_byte_i (s1_byte_q),
    .frame_o      (frame_d),
    .frame_end_o  (frame_end),
    .result_o     (result_d)
  );

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!frame_end || out_free);
  assign in_ready_o = !s1_valid_q || s1_fire;
  assign in_accept  = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_bit_mode <= 1'b1;
      cfg_q.width        <= 13'(bib_pkg::MaxHeight);
      cfg_q.height       <= 13'(bib_pkg::MaxHeight);
      cfg_q.line_bytes   <= 10'(bib_pkg::MaxLineBytes);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bib_pkg::CfgOneBitMode: cfg_q.one_bit_mode <= cfg_data_i[0];
        bib_pkg::CfgWidth:      cfg_q.width        <= cfg_data_i;
        bib_pkg::CfgHeight:     cfg_q.height       <= cfg_data_i;
        bib_pkg::CfgLineBytes:  cfg_q.line_bytes   <= cfg_data_i[9:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      frame_q     <= bib_pkg::FrameClear;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire && frame_end) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        frame_q <= frame_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= pixel_byte_i;
    end
    if (s1_fire && frame_end) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign top_row_o     = out_q.top_row;
  assign bottom_row_o  = out_q.bottom_row;
  assign left_col_o    = out_q.left_col;
  assign right_col_o   = out_q.right_col;
  assign empty_frame_o = out_q.empty_frame;

`ifndef ASSERT_OFF
  // A frame-end item always leaves a result behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire && frame_end |=> out_valid_q)
    else $error("frame end did not load the result register");

  // Once a pixel is seen, the running box is never inverted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q.any_set |-> (frame_q.min_drow <= {1'b0, frame_q.max_drow}) &&
                        (frame_q.min_col <= {1'b0, frame_q.max_col}))
    else $error("running bounding box is inverted");

  // Without a set pixel the extremes still hold their cleared values.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !frame_q.any_set |-> (frame_q.min_drow == '1) && (frame_q.max_drow == '0) &&
                         (frame_q.min_col == '1) && (frame_q.max_col == '0))
    else $error("extremes changed without a set pixel");
`endif

endmodule

@@ sv/bib_step.sv @@
`timescale 1ns / 1ps
module bib_step (
  input  bib_pkg::cfg_t    cfg_i,
  input  bib_pkg::frame_t  frame_i,
  input  logic [7:0]       pixel_byte_i,
  output bib_pkg::frame_t  frame_o,
  output logic             frame_end_o,
  output bib_pkg::result_t result_o
);

  logic [12:0]     h;
  logic [12:0]     w;
  logic [9:0]      lb;
  logic [12:0]     h_m1;
  logic [12:0]     w_m1;
  logic [12:0]     rc_ext;
  logic [11:0]     drow;
  logic [11:0]     left_pix;
  logic [11:0]     right_pix;
  logic            row_end;
  bib_pkg::frame_t upd;

  always_comb begin
    if (cfg_i.height == 13'd0) begin
      h = 13'd1;
    end else if (cfg_i.height > 13'(bib_pkg::MaxHeight)) begin
      h = 13'(bib_pkg::MaxHeight);
    end else begin
      h = cfg_i.height;
    end
    if (cfg_i.width == 13'd0) begin
      w = 13'd1;
    end else if (cfg_i.width > 13'(bib_pkg::MaxHeight)) begin
      w = 13'(bib_pkg::MaxHeight);
    end else begin
      w = cfg_i.width;
    end
    if (cfg_i.line_bytes == 10'd0) begin
      lb = 10'd1;
    end else if (cfg_i.line_bytes > 10'(bib_pkg::MaxLineBytes)) begin
      lb = 10'(bib_pkg::MaxLineBytes);
    end else begin
      lb = cfg_i.line_bytes;
    end
  end

  assign h_m1   = h - 13'd1;
  assign w_m1   = w - 13'd1;
  assign rc_ext = {1'b0, frame_i.row_count};

  // Stored rows past the frame height fold onto display row 0.
  always_comb begin
    logic [12:0] diff;
    diff = h_m1 - rc_ext;
    drow = (rc_ext <= h_m1) ? diff[11:0] : 12'd0;
  end

  assign left_pix  = {frame_i.byte_col, bib_pkg::first_set(pixel_byte_i)};
  assign right_pix = {frame_i.byte_col, bib_pkg::last_set(pixel_byte_i)};

  always_comb begin
    upd = frame_i;
    if (pixel_byte_i != 8'd0) begin
      if ({1'b0, drow} < frame_i.min_drow) begin
        upd.min_drow = {1'b0, drow};
      end
      if (drow > frame_i.max_drow) begin
        upd.max_drow = drow;
      end
      if ({1'b0, left_pix} < frame_i.min_col) begin
        upd.min_col = {1'b0, left_pix};
      end
      if (right_pix > frame_i.max_col) begin
        upd.max_col = right_pix;
      end
      upd.any_set = 1'b1;
    end
  end

  assign row_end     = ({1'b0, frame_i.byte_col} + 10'd1) >= lb;
  assign frame_end_o = row_end && ((rc_ext + 13'd1) >= h);

  always_comb begin
    frame_o = upd;
    if (frame_end_o) begin
      frame_o = bib_pkg::FrameClear;
    end else if (row_end) begin
      frame_o.byte_col  = 9'd0;
      frame_o.row_count = frame_i.row_count + 12'd1;
    end else begin
      frame_o.byte_col  = frame_i.byte_col + 9'd1;
    end
  end

  always_comb begin
    logic [9:0] lb_p1;
    lb_p1 = lb + 10'd1;
    if (!cfg_i.one_bit_mode) begin
      result_o.top_row     = 13'd0;
      result_o.bottom_row  = h_m1[11:0];
      result_o.left_col    = 13'd0;
      result_o.right_col   = w_m1[11:0];
      result_o.empty_frame = 1'b0;
    end else if (!upd.any_set) begin
      result_o.top_row     = h;
      result_o.bottom_row  = 12'd0;
      result_o.left_col    = {lb_p1, 3'b000};
      result_o.right_col   = 12'd0;
      result_o.empty_frame = 1'b1;
    end else begin
      result_o.top_row     = upd.min_drow;
      result_o.bottom_row  = upd.max_drow;
      result_o.left_col    = upd.min_col;
      result_o.right_col   = upd.max_col;
      result_o.empty_frame = 1'b0;
    end
  end

endmodule

@@ sim/bib_checker.sv @@
`timescale 1ns / 1ps
module bib_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  pixel_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [12:0] top_row_i,
  input  logic [11:0] bottom_row_i,
  input  logic [12:0] left_col_i,
  input  logic [11:0] right_col_i,
  input  logic        empty_frame_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  output int          fail_cnt_o,
  output int          pending_o
);

  logic              one_bit_q;
  logic [12:0]       width_q;
  logic [12:0]       height_q;
  logic [9:0]        lbytes_q;
  bib_pkg::frame_t   run_box;
  bib_pkg::result_t  pending_boxes[$];
  int                report_cnt;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) begin
      return 1;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Folds one pixel byte into the running box and queues a box at frame end.
  task automatic fold_pixel_byte(input logic [7:0] b);
    int unsigned      h;
    int unsigned      w;
    int unsigned      lb;
    int unsigned      drow;
    int unsigned      kl;
    int unsigned      kr;
    int unsigned      base;
    logic             row_end;
    logic             frame_end;
    bib_pkg::result_t box;
    h  = clamp_dim(height_q, bib_pkg::MaxHeight);
    w  = clamp_dim(width_q, bib_pkg::MaxHeight);
    lb = clamp_dim(lbytes_q, bib_pkg::MaxLineBytes);
    if (b != 8'h00) begin
      // Rows past the frame height, left over from a height change, land on row 0.
      drow = (run_box.row_count <= h - 1) ? h - 1 - run_box.row_count : 0;
      kl = 0;
      while (!b[7 - kl]) kl++;
      kr = 7;
      while (!b[7 - kr]) kr--;
      base = int'(run_box.byte_col) * 8;
      if (drow < run_box.min_drow) run_box.min_drow = 13'(drow);
      if (drow > run_box.max_drow) run_box.max_drow = 12'(drow);
      if (base + kl < run_box.min_col) run_box.min_col = 13'(base + kl);
      if (base + kr > run_box.max_col) run_box.max_col = 12'(base + kr);
      run_box.any_set = 1'b1;
    end
    row_end   = (int'(run_box.byte_col) + 1 >= lb);
    frame_end = row_end && (int'(run_box.row_count) + 1 >= h);
    if (!frame_end) begin
      if (row_end) begin
        run_box.byte_col  = '0;
        run_box.row_count = run_box.row_count + 12'd1;
      end else begin
        run_box.byte_col = run_box.byte_col + 9'd1;
      end
    end else begin
      if (!one_bit_q) begin
        box.top_row     = '0;
        box.bottom_row  = 12'(h - 1);
        box.left_col    = '0;
        box.right_col   = 12'(w - 1);
        box.empty_frame = 1'b0;
      end else if (!run_box.any_set) begin
        box.top_row     = 13'(h);
        box.bottom_row  = '0;
        box.left_col    = 13'((lb + 1) * 8);
        box.right_col   = '0;
        box.empty_frame = 1'b1;
      end else begin
        box.top_row     = run_box.min_drow;
        box.bottom_row  = run_box.max_drow;
        box.left_col    = run_box.min_col;
        box.right_col   = run_box.max_col;
        box.empty_frame = 1'b0;
      end
      pending_boxes.push_back(box);
      run_box = bib_pkg::FrameClear;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bib_pkg::result_t got;
    bib_pkg::result_t want;
    if (!rst_ni) begin
      one_bit_q  = 1'b1;
      width_q    = 13'd4096;
      height_q   = 13'd4096;
      lbytes_q   = 10'd512;
      run_box    = bib_pkg::FrameClear;
      pending_boxes.delete();
      fail_cnt_o = 0;
      report_cnt = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bib_pkg::CfgOneBitMode: one_bit_q = cfg_data_i[0];
          bib_pkg::CfgWidth:      width_q   = cfg_data_i;
          bib_pkg::CfgHeight:     height_q  = cfg_data_i;
          bib_pkg::CfgLineBytes:  lbytes_q  = cfg_data_i[9:0];
          default: ;
        endcase
      end
      // Results are checked before this edge's byte is folded, since a byte cannot
      // produce its box on the edge that accepts it.
      if (out_valid_i && out_ready_i) begin
        got = '{top_row: top_row_i, bottom_row: bottom_row_i, left_col: left_col_i,
                right_col: right_col_i, empty_frame: empty_frame_i};
        if (pending_boxes.size() == 0) begin
          fail_cnt_o++;
          if (report_cnt < 10) begin
            report_cnt++;
            $display("unexpected box: top=%0d bottom=%0d left=%0d right=%0d empty=%0d",
                     got.top_row, got.bottom_row, got.left_col, got.right_col,
                     got.empty_frame);
          end
        end else begin
          want = pending_boxes.pop_front();
          if (got.top_row !== want.top_row || got.bottom_row !== want.bottom_row ||
              got.left_col !== want.left_col || got.right_col !== want.right_col ||
              got.empty_frame !== want.empty_frame) begin
            fail_cnt_o++;
            if (report_cnt < 10) begin
              report_cnt++;
              $display("box mismatch at %0t: exp top=%0d bottom=%0d left=%0d right=%0d empty=%0d",
                       $realtime, want.top_row, want.bottom_row, want.left_col,
                       want.right_col, want.empty_frame);
              $display("                    got top=%0d bottom=%0d left=%0d right=%0d empty=%0d",
                       got.top_row, got.bottom_row, got.left_col, got.right_col,
                       got.empty_frame);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        fold_pixel_byte(pixel_byte_i);
      end
      pending_o = pending_boxes.size();
    end
  end

endmodule

@@ sim/tb_binary_image_bounding_box.sv @@
`timescale 1ns / 1ps
module tb_binary_image_bounding_box;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  pixel_byte;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [12:0] top_row;
  logic [11:0] bottom_row;
  logic [12:0] left_col;
  logic [11:0] right_col;
  logic        empty_frame;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [12:0] cfg_data;
  int          fail_cnt;
  int          boxes_due;

  logic        calm = 1'b0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  always #5 clk = ~clk;

  binary_image_bounding_box DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .pixel_byte_i (pixel_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .top_row_o    (top_row),
    .bottom_row_o (bottom_row),
    .left_col_o   (left_col),
    .right_col_o  (right_col),
    .empty_frame_o(empty_frame),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data)
  );

  bib_checker box_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .pixel_byte_i (pixel_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .top_row_i    (top_row),
    .bottom_row_i (bottom_row),
    .left_col_i   (left_col),
    .right_col_i  (right_col),
    .empty_frame_i(empty_frame),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_cnt_o   (fail_cnt),
    .pending_o    (boxes_due)
  );

  // Result side: random stalls, plus one long hold-off started by a toggle from stimulus.
  always @(negedge clk) begin
    if (hold_toggle != hold_seen) begin
      hold_seen = hold_toggle;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= 18);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    pixel_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Waits until every queued box has arrived and the last byte has been folded in.
  task automatic drain();
    in_valid <= 1'b0;
    while (boxes_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_frame(input logic obm, input logic [12:0] w, input logic [12:0] h,
                           input logic [12:0] lb);
    drain();
    write_reg(bib_pkg::CfgOneBitMode, {12'd0, obm});
    write_reg(bib_pkg::CfgWidth, w);
    write_reg(bib_pkg::CfgHeight, h);
    write_reg(bib_pkg::CfgLineBytes, lb);
  endtask

  // Mostly blank bytes and single pixels, so that empty frames and edge columns show up.
  function automatic logic [7:0] rand_pixels();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'h00;
      4, 5:       return 8'h01 << $urandom_range(7);
      6:          return 8'hFF;
      default:    return 8'($urandom);
    endcase
  endfunction

  initial begin
    int          rand_sent;
    int          phase;
    int          n_bytes;
    logic [12:0] h_val;
    logic [12:0] w_val;
    logic [12:0] lb_val;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    pixel_byte = 8'h00;
    cfg_we     = 1'b0;
    cfg_idx    = bib_pkg::CfgOneBitMode;
    cfg_data   = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Two rows of two bytes: corner pixels, an empty frame, a full byte.
    set_frame(1'b1, 13'd16, 13'd2, 13'd2);
    send_byte(8'h80); send_byte(8'h00); send_byte(8'h00); send_byte(8'h01);
    repeat (4) send_byte(8'h00);
    send_byte(8'hFF); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
    // Full frame mode, with a width above the maximum and then a zero width.
    set_frame(1'b0, 13'd8191, 13'd2, 13'd2);
    repeat (4) send_byte(rand_pixels());
    set_frame(1'b0, 13'd0, 13'd0, 13'd0);
    send_byte(8'h5A);
    // Zero height and line length count as one: every byte is a frame.
    set_frame(1'b1, 13'd1, 13'd0, 13'd0);
    send_byte(8'h01); send_byte(8'h00); send_byte(8'h7F);

    // Tallest frame: a pixel in stored row 0, then the height shrinks mid-frame.
    set_frame(1'b1, 13'd100, 13'd8191, 13'd1);
    send_byte(8'h10);
    drain();
    write_reg(bib_pkg::CfgHeight, 13'd2);
    send_byte(8'h40);
    // Widest row: a pixel in the last column.
    set_frame(1'b1, 13'd100, 13'd1, 13'd1023);
    for (int i = 0; i < 512; i++) send_byte(i == 511 ? 8'h01 : 8'h00);

    rand_sent = 0;
    phase     = 0;
    while (rand_sent < 800) begin
      calm <= (phase >= 12 && phase < 18);
      if (phase == 5) begin
        // One-byte frames while the result side holds off, so the block backs up.
        set_frame(1'b1, 13'($urandom_range(1, 4096)), 13'd1, 13'd1);
        hold_toggle <= ~hold_toggle;
        n_bytes = 40;
      end else begin
        case ($urandom_range(19))
          0:       h_val = 13'd0;
          1:       h_val = 13'($urandom_range(4097, 8191));
          2:       h_val = 13'($urandom_range(7, 64));
          default: h_val = 13'($urandom_range(1, 6));
        endcase
        case ($urandom_range(19))
          0:       lb_val = 13'd0;
          1:       lb_val = 13'($urandom_range(513, 1023));
          2:       lb_val = 13'($urandom_range(7, 40));
          default: lb_val = 13'($urandom_range(1, 6));
        endcase
        case ($urandom_range(3))
          0:       w_val = 13'd4096;
          1:       w_val = 13'd1;
          default: w_val = 13'($urandom_range(8191));
        endcase
        // A new setting usually lands mid-frame: the counters carry over.
        set_frame($urandom_range(7) != 0, w_val, h_val, lb_val);
        n_bytes = $urandom_range(5, 60);
      end
      repeat (n_bytes) send_byte(rand_pixels());
      rand_sent += n_bytes;
      phase++;
    end

    drain();
    repeat (10) @(negedge clk);
    if (fail_cnt == 0 && boxes_due == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
